// ===== rtl/rdnu_pkg.sv =====
// rdnu_pkg: shared types, codes and helpers of the RLE / nibble-delta unpacker.
// No dependencies; used by every module under rtl/.
`default_nettype none

package rdnu_pkg;

  localparam int SIZE_BITS_DEF = 48;   // width of the owed-byte counter
  localparam int QDEPTH        = 4;    // result queue entries
  localparam int CNT_W         = 32;   // header element count
  localparam int ESZ_W         = 16;   // header element size
  localparam int PROD_W        = CNT_W + ESZ_W;
  localparam int LEN_W         = 14;   // run length / pending count

  localparam logic KIND_RUN    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_HDR  = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_HDR    = 4'd0,
    PH_BAD    = 4'd1,
    PH_TOKEN  = 4'd2,
    PH_DONE   = 4'd3,
    PH_LITLEN = 4'd4,
    PH_LIT    = 4'd5,
    PH_DLEN   = 4'd6,
    PH_DELTA  = 4'd7,
    PH_CNT    = 4'd8,
    PH_VALUE  = 4'd9,
    PH_STEP   = 4'd10
  } phase_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       first;
    logic [7:0]       step;
    logic [LEN_W-1:0] run_len;
    status_t          status;
    logic             last;
  } result_t;

  // results written into the queue by one accepted byte (0, 1 or 2)
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } wr_t;

  // step of the fixed-step run tokens 0x60..0x7F, picked by bits 4:3
  function automatic logic [7:0] fixed_step(input logic [7:0] t);
    logic [7:0] s;
    unique case (t[4:3])
      2'b00:   s = 8'hFE;
      2'b01:   s = 8'hFF;
      2'b10:   s = 8'h01;
      default: s = 8'h02;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rdnu_hdr.sv =====
// rdnu_hdr: header capture (element count, element size) and total-size multiplier.
// Depends on rdnu_pkg.
`default_nettype none

module rdnu_hdr #(
  parameter int SIZE_BITS = rdnu_pkg::SIZE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 hdr_wr,
  input  wire logic [2:0]           hdr_idx,
  input  wire logic [7:0]           hdr_byte,
  output logic      [SIZE_BITS-1:0] total,
  output logic                      hdr_bad
);

  localparam int PW = rdnu_pkg::PROD_W;
  // all ones in SIZE_BITS; wraps cleanly when SIZE_BITS == PW
  localparam logic [PW-1:0] LIM = (PW'(1) << SIZE_BITS) - PW'(1);

  logic [rdnu_pkg::CNT_W-1:0] count_r;
  logic [rdnu_pkg::ESZ_W-1:0] esize_r;
  logic [PW-1:0]              prod_r;
  logic [PW-1:0]              sat;

  // every header byte is overwritten before use, so no clearing
  always_ff @(posedge clk) begin
    if (hdr_wr) begin
      if (hdr_idx[2] == 1'b0) begin
        count_r[hdr_idx[1:0]*8 +: 8] <= hdr_byte;
      end else if (hdr_idx[1] == 1'b0) begin
        esize_r[hdr_idx[0]*8 +: 8] <= hdr_byte;
      end
    end
    // settles before the eighth header byte arrives
    prod_r <= PW'(count_r) * PW'(esize_r);
  end

  always_comb begin
    sat     = (prod_r > LIM) ? LIM : prod_r;
    total   = sat[SIZE_BITS-1:0];
    hdr_bad = (count_r == '0) || (esize_r == '0);
  end

endmodule

`default_nettype wire

// ===== rtl/rdnu_decode.sv =====
// rdnu_decode: token state machine, run clipping and status generation.
// Depends on rdnu_pkg; takes the total size from rdnu_hdr.
`default_nettype none

module rdnu_decode #(
  parameter int SIZE_BITS = rdnu_pkg::SIZE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_acc,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 eos,
  input  wire logic [SIZE_BITS-1:0] total,
  input  wire logic                 hdr_bad,
  output logic                      hdr_wr,
  output logic      [2:0]           hdr_idx,
  output rdnu_pkg::wr_t             wr
);

  localparam int LW = rdnu_pkg::LEN_W;
  localparam logic [7:0] NIB_BIAS = 8'hF9;   // adds nibble - 7
  localparam logic [2:0] HDR_LAST = 3'd7;

  rdnu_pkg::phase_t   phase_r, phase_nxt;
  logic [2:0]         idx_r, idx_nxt;
  logic [SIZE_BITS-1:0] owed_r, owed_nxt;
  logic [7:0]         token_r, token_nxt;
  logic [LW-1:0]      pend_r, pend_nxt;
  logic [7:0]         rval_r, rval_nxt;
  logic [7:0]         rbyte_r, rbyte_nxt;

  logic               em_on;
  logic [7:0]         em_first, em_step;
  logic [LW-1:0]      em_len, take;
  logic               owed_lt, tok_done, run_v;
  logic [7:0]         dl_a, dl_s;
  logic               step_run;
  rdnu_pkg::phase_t   tok_end;
  rdnu_pkg::phase_t   ph_adv;    // phase after this byte, before the stream reset
  rdnu_pkg::status_t  st;
  rdnu_pkg::result_t  run_res, st_res;

  assign hdr_idx  = idx_r;
  assign hdr_wr   = in_acc && (phase_r == rdnu_pkg::PH_HDR);
  assign step_run = (token_r[7:5] == 3'b010);   // step run and long step run
  assign dl_a     = rbyte_r + {4'h0, data_byte[7:4]} + NIB_BIAS;
  assign dl_s     = {4'h0, data_byte[3:0]} + NIB_BIAS;

  // run that this byte would emit, before clipping
  always_comb begin
    em_on    = 1'b0;
    em_first = data_byte;
    em_step  = 8'h00;
    em_len   = pend_r;
    unique case (phase_r)
      rdnu_pkg::PH_LIT: begin
        em_on  = 1'b1;
        em_len = LW'(1);
      end
      rdnu_pkg::PH_DELTA: begin
        em_on    = 1'b1;
        em_first = dl_a;
        em_step  = dl_s;
        em_len   = LW'(2);
      end
      rdnu_pkg::PH_VALUE: begin
        em_on   = !step_run;
        em_step = (token_r[7:5] == 3'b011) ? rdnu_pkg::fixed_step(token_r) : 8'h00;
      end
      rdnu_pkg::PH_STEP: begin
        em_on    = 1'b1;
        em_first = rval_r;
        em_step  = data_byte;
      end
      default: begin
        em_on = 1'b0;
      end
    endcase
  end

  // clip to the bytes still owed
  always_comb begin
    owed_lt  = owed_r < SIZE_BITS'(em_len);
    take     = owed_lt ? owed_r[LW-1:0] : em_len;
    tok_done = !(owed_r > SIZE_BITS'(em_len));   // nothing owed after this run
    run_v    = in_acc && em_on && (owed_r != '0);
    tok_end  = tok_done ? rdnu_pkg::PH_DONE : rdnu_pkg::PH_TOKEN;
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    ph_adv    = phase_r;
    idx_nxt   = idx_r;
    owed_nxt  = owed_r;
    token_nxt = token_r;
    pend_nxt  = pend_r;
    rval_nxt  = rval_r;
    rbyte_nxt = rbyte_r;
    if (in_acc) begin
      if (em_on) begin
        owed_nxt = owed_r - SIZE_BITS'(take);
      end
      unique case (phase_r)
        rdnu_pkg::PH_HDR: begin
          if (idx_r == HDR_LAST) begin
            if (hdr_bad) begin
              phase_nxt = rdnu_pkg::PH_BAD;
            end else begin
              owed_nxt  = total;
              phase_nxt = rdnu_pkg::PH_TOKEN;
            end
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        rdnu_pkg::PH_TOKEN: begin
          token_nxt = data_byte;
          priority if (data_byte[7:5] == 3'b100) begin            // literal
            pend_nxt  = LW'({data_byte[4:0]}) + LW'(1);
            phase_nxt = rdnu_pkg::PH_LIT;
          end else if (data_byte[7:5] == 3'b101) begin           // long literal
            pend_nxt  = LW'({data_byte[4:0], 8'h00});
            phase_nxt = rdnu_pkg::PH_LITLEN;
          end else if (data_byte[7:6] == 2'b11) begin            // delta
            rbyte_nxt = {data_byte[4:1], 4'h0};
            if (data_byte[5]) begin
              pend_nxt  = LW'({data_byte[0], 8'h00});
              phase_nxt = rdnu_pkg::PH_DLEN;
            end else begin
              pend_nxt  = LW'(data_byte[0]) + LW'(2);
              phase_nxt = rdnu_pkg::PH_DELTA;
            end
          end else if (data_byte[7:5] == 3'b001) begin           // long repeat
            pend_nxt  = LW'({data_byte[4:0], 8'h00});
            phase_nxt = rdnu_pkg::PH_CNT;
          end else if (data_byte[7:4] == 4'h5) begin             // long step run
            pend_nxt  = LW'({data_byte[3:0], 8'h00});
            phase_nxt = rdnu_pkg::PH_CNT;
          end else if (data_byte[7:4] == 4'h4) begin             // step run
            pend_nxt  = LW'(data_byte[3:0]) + LW'(1);
            phase_nxt = rdnu_pkg::PH_VALUE;
          end else if (data_byte[7:5] == 3'b011) begin           // fixed step run
            pend_nxt  = LW'(data_byte[2:0]) + LW'(1);
            phase_nxt = rdnu_pkg::PH_VALUE;
          end else begin                                         // repeat
            pend_nxt  = LW'(data_byte[4:0]) + LW'(1);
            phase_nxt = rdnu_pkg::PH_VALUE;
          end
        end
        rdnu_pkg::PH_LITLEN: begin
          pend_nxt  = (pend_r | LW'(data_byte)) + LW'(1);
          phase_nxt = rdnu_pkg::PH_LIT;
        end
        rdnu_pkg::PH_LIT: begin
          pend_nxt = pend_r - LW'(1);
          if (pend_r == LW'(1)) phase_nxt = tok_end;
        end
        rdnu_pkg::PH_DLEN: begin
          pend_nxt  = (pend_r | LW'(data_byte)) + LW'(2);
          phase_nxt = rdnu_pkg::PH_DELTA;
        end
        rdnu_pkg::PH_DELTA: begin
          rbyte_nxt = dl_a + dl_s;
          pend_nxt  = pend_r - LW'(1);
          if (pend_r == LW'(1)) phase_nxt = tok_end;
        end
        rdnu_pkg::PH_CNT: begin
          pend_nxt  = (pend_r | LW'(data_byte)) + LW'(1);
          phase_nxt = rdnu_pkg::PH_VALUE;
        end
        rdnu_pkg::PH_VALUE: begin
          rval_nxt  = data_byte;
          phase_nxt = step_run ? rdnu_pkg::PH_STEP : tok_end;
        end
        rdnu_pkg::PH_STEP: begin
          phase_nxt = tok_end;
        end
        default: begin
          phase_nxt = phase_r;   // done or bad header: byte ignored
        end
      endcase
      ph_adv = phase_nxt;
      if (eos) begin
        phase_nxt = rdnu_pkg::PH_HDR;
        idx_nxt   = 3'd0;
      end
    end
  end

  // status from the state after this byte, before the stream reset
  always_comb begin
    unique case (ph_adv)
      rdnu_pkg::PH_HDR, rdnu_pkg::PH_BAD:              st = rdnu_pkg::ST_BAD_HDR;
      rdnu_pkg::PH_TOKEN, rdnu_pkg::PH_DELTA, rdnu_pkg::PH_DONE:
        st = (owed_nxt != '0) ? rdnu_pkg::ST_MISMATCH : rdnu_pkg::ST_OK;
      default:                                         st = rdnu_pkg::ST_TRUNC;
    endcase
  end

  // results to the queue
  always_comb begin
    run_res.kind    = rdnu_pkg::KIND_RUN;
    run_res.first   = em_first;
    run_res.step    = em_step;
    run_res.run_len = take;
    run_res.status  = rdnu_pkg::ST_OK;
    run_res.last    = !eos;
    st_res.kind     = rdnu_pkg::KIND_STATUS;
    st_res.first    = 8'h00;
    st_res.step     = 8'h00;
    st_res.run_len  = '0;
    st_res.status   = st;
    st_res.last     = 1'b1;
    wr.n  = {1'b0, run_v} + {1'b0, in_acc && eos};
    wr.r0 = run_v ? run_res : st_res;
    wr.r1 = st_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rdnu_pkg::PH_HDR;
      idx_r   <= 3'd0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
    owed_r  <= owed_nxt;
    token_r <= token_nxt;
    pend_r  <= pend_nxt;
    rval_r  <= rval_nxt;
    rbyte_r <= rbyte_nxt;
  end

  // end of stream always returns to the header phase
  a_eos_rst: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && eos |=> phase_r == rdnu_pkg::PH_HDR && idx_r == 3'd0)
    else $error("stream end did not return to header phase");

  // once the total is reached the rest of the stream adds nothing
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rdnu_pkg::PH_DONE |-> !run_v)
    else $error("run emitted after total reached");

  // two results from one byte only when the second is the status
  a_two_res: assert property (@(posedge clk) disable iff (!rst_n)
    wr.n == 2'd2 |-> wr.r0.kind == rdnu_pkg::KIND_RUN && wr.r1.kind == rdnu_pkg::KIND_STATUS)
    else $error("bad result pair");

endmodule

`default_nettype wire

// ===== rtl/rdnu_outq.sv =====
// rdnu_outq: small result queue, up to two writes and one read per cycle.
// Depends on rdnu_pkg.
`default_nettype none

module rdnu_outq #(
  parameter int DEPTH = rdnu_pkg::QDEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rdnu_pkg::wr_t  wr,
  output logic                room,      // space for two more results
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output rdnu_pkg::result_t   rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rdnu_pkg::result_t mem [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign room     = cnt_r <= CW'(DEPTH - 2);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem[rp_r];
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r + PW'(wr.n);
    rp_nxt  = rp_r + PW'(pop);
    cnt_nxt = cnt_r + CW'(wr.n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (wr.n != 2'd0) mem[wp_r] <= wr.r0;
    if (wr.n == 2'd2) mem[wp_r + PW'(1)] <= wr.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    wr.n != 2'd0 |-> cnt_r <= CW'(DEPTH - 2))
    else $error("result queue written without room");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> cnt_r == $past(cnt_r) + CW'($past(wr.n)) - CW'($past(pop)))
    else $error("queue count lost track");

endmodule

`default_nettype wire

// ===== rtl/rle_delta_nibble_unpacker.sv =====
// rle_delta_nibble_unpacker: top level of the RLE / nibble-delta stream unpacker.
// Depends on rdnu_pkg, rdnu_hdr, rdnu_decode and rdnu_outq.
`default_nettype none

// Channel  Dir  Width  Contents
// in       in   8+1    tdata = data_byte, tlast = end_of_stream
// out      out  32+1+1 tdata = first_value, step, run_length, status;
//                      tuser = kind, tlast = last_of_input
//
// One compressed byte per cycle while in_tready is high: the token state machine
// decodes each request in the cycle it is accepted and writes 0, 1 or 2 results
// into a 4-entry queue. A byte that ends the stream adds the status result behind
// its run. in_tready drops while the queue has fewer than two free entries; output
// stalls never lose results. Reset (rst_n low, synchronous) returns to the
// header phase with the queue empty; the header product is registered from the
// captured count and size once the sixth header byte is in.
module rle_delta_nibble_unpacker #(
  parameter int SIZE_BITS = rdnu_pkg::SIZE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic        in_tlast,    // end_of_stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,   // [7:0] first_value, [15:8] step,
                                        // [29:16] run_length, [31:30] status
  output logic             out_tuser,   // [0] kind: run or final status
  output logic             out_tlast    // last_of_input
);

  logic                 in_acc;
  logic                 hdr_wr, hdr_bad;
  logic [2:0]           hdr_idx;
  logic [SIZE_BITS-1:0] total;
  rdnu_pkg::wr_t        wr;
  rdnu_pkg::result_t    res;

  assign in_acc = in_tvalid && in_tready;

  rdnu_hdr #(
    .SIZE_BITS(SIZE_BITS)
  ) u_hdr (
    .clk      (clk),
    .hdr_wr   (hdr_wr),
    .hdr_idx  (hdr_idx),
    .hdr_byte (in_tdata),
    .total    (total),
    .hdr_bad  (hdr_bad)
  );

  rdnu_decode #(
    .SIZE_BITS(SIZE_BITS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .data_byte (in_tdata),
    .eos       (in_tlast),
    .total     (total),
    .hdr_bad   (hdr_bad),
    .hdr_wr    (hdr_wr),
    .hdr_idx   (hdr_idx),
    .wr        (wr)
  );

  rdnu_outq #(
    .DEPTH(rdnu_pkg::QDEPTH)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .room     (in_tready),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (res)
  );

  assign out_tdata = {res.status, res.run_len, res.step, res.first};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

`default_nettype wire
